/* hdl/session_energy_integrator_top_defines.svh */
// Assertion macros for the session energy integrator.
// Included by the top level; depends on nothing else.
`ifndef SESSION_ENERGY_INTEGRATOR_TOP_DEFINES_SVH
`define SESSION_ENERGY_INTEGRATOR_TOP_DEFINES_SVH

// Same-cycle implication, disabled while reset is low.
`define SEI_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sei assertion failed");

// Next-cycle implication, disabled while reset is low.
`define SEI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sei assertion failed");

`endif

/* hdl/sei_pkg.sv */
// Shared types and constants of the session energy integrator.
// No dependencies; imported by sei_front, sei_back and the top level.
`timescale 1ns / 1ps
`default_nettype none

package sei_pkg;

    localparam int OPCODE_W = 2;
    localparam int POWER_W  = 24;
    localparam int PWR_W    = 23;
    localparam int STAMP_W  = 32;
    localparam int REASON_W = 4;
    localparam int STATUS_W = 2;
    localparam int ENERGY_W = 48;

    localparam logic [ENERGY_W-1:0] ENERGY_MAX = '1;

    localparam logic [OPCODE_W-1:0] OP_SAMPLE = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_BEGIN  = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_FINISH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_REJECT  = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_INVALID = 2'd2;

    typedef enum logic [2:0] {
        KIND_SAMPLE,
        KIND_INVALID,
        KIND_BEGIN,
        KIND_FINISH,
        KIND_REJECT
    } t_kind;

    typedef struct packed {
        t_kind               kind;
        logic [PWR_W-1:0]    power;
        logic [STAMP_W-1:0]  stamp;
        logic [REASON_W-1:0] reason;
    } t_cmd;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_MUL,
        BK_ACC
    } t_back_state;

endpackage

`default_nettype wire

/* hdl/sei_front.sv */
// Front part: classifies each request and queues it for the back part.
// Depends on sei_pkg.
`timescale 1ns / 1ps
`default_nettype none

module sei_front #(
    parameter int DEPTH = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_push,
    output logic                           o_full,
    input  logic [sei_pkg::OPCODE_W-1:0]   i_opcode,
    input  logic                           i_sample_valid,
    input  logic signed [sei_pkg::POWER_W-1:0] i_power_mw,
    input  logic [sei_pkg::STAMP_W-1:0]    i_stamp_ms,
    input  logic [sei_pkg::REASON_W-1:0]   i_stop_reason,
    output logic                           o_head_valid,
    output sei_pkg::t_cmd                  o_head,
    input  logic                           i_pop
);
    import sei_pkg::*;

    localparam int AW = $clog2(DEPTH);

    t_cmd              r_mem [DEPTH];
    logic [AW-1:0]     r_wr;
    logic [AW-1:0]     r_rd;
    logic [AW:0]       r_count;
    t_cmd              w_cmd;
    logic [PWR_W-1:0]  w_clamped;
    logic              w_wr;

    assign w_clamped = i_power_mw[POWER_W-1] ? '0 : i_power_mw[PWR_W-1:0];

    always_comb begin
        w_cmd.power  = w_clamped;
        w_cmd.stamp  = i_stamp_ms;
        w_cmd.reason = i_stop_reason;
        unique case (i_opcode)
            OP_SAMPLE: begin
                w_cmd.kind = i_sample_valid ? KIND_SAMPLE : KIND_INVALID;
            end
            OP_BEGIN: begin
                w_cmd.kind  = KIND_BEGIN;
                w_cmd.power = i_sample_valid ? w_clamped : '0;
            end
            OP_FINISH: begin
                w_cmd.kind = KIND_FINISH;
            end
            default: begin
                w_cmd.kind = KIND_REJECT;
            end
        endcase
    end

    assign o_full       = (r_count == (AW+1)'(DEPTH));
    assign o_head_valid = (r_count != '0);
    assign o_head       = r_mem[r_rd];
    assign w_wr         = i_push && !o_full;

    always_ff @(posedge i_clk) begin
        if (w_wr) begin
            r_mem[r_wr] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (w_wr) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (w_wr && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (!w_wr && i_pop) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

/* hdl/sei_div.sv */
// Divider by a fixed divisor: reciprocal multiply, then remainder and carry fix-up.
// No dependencies; register chain r_x, r_mhi, r_qe, r_re, r_quot; done flags r_quot.
`timescale 1ns / 1ps
`default_nettype none

module sei_div #(
    parameter int DIVISOR = 1000,
    parameter int DW      = 32,
    parameter int LW      = (DIVISOR > 1) ? $clog2(DIVISOR) : 1
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [DW-1:0] i_dividend,
    input  logic [LW-1:0] i_carry,
    output logic          o_done,
    output logic [DW:0]   o_quot,
    output logic [LW-1:0] o_rem
);
    localparam int SH = $clog2(DIVISOR);
    // reciprocal is 2^DW + M_LOW; the 2^DW part is the add of r_x below
    localparam logic [2*DW-1:0] M_FULL =
        ((2*DW)'(1) << (DW + SH)) / (2*DW)'(DIVISOR) + (2*DW)'(1);
    localparam logic [DW-1:0] M_LOW = M_FULL[DW-1:0];
    localparam logic [DW-1:0] DIV_C = DW'(DIVISOR);
    localparam logic [LW:0]   DIV_S = (LW+1)'(DIVISOR);

    logic [4:0]      r_vld;
    logic [DW-1:0]   r_x;
    logic [LW-1:0]   r_c;
    logic [DW-1:0]   r_mhi;
    logic [DW-1:0]   r_qe;
    logic [LW-1:0]   r_re;
    logic [DW:0]     r_quot;
    logic [LW-1:0]   r_rem;
    logic [2*DW-1:0] w_prod;
    logic [DW:0]     w_qsum;
    logic [DW-1:0]   w_qd;
    logic [DW-1:0]   w_re;
    logic [LW:0]     w_rsum;

    assign w_prod = {{DW{1'b0}}, r_x} * {{DW{1'b0}}, M_LOW};
    assign w_qsum = {1'b0, r_mhi} + {1'b0, r_x};
    assign w_qd   = r_qe * DIV_C;
    assign w_re   = r_x - w_qd;
    assign w_rsum = {1'b0, r_re} + {1'b0, r_c};

    assign o_done = r_vld[4];
    assign o_quot = r_quot;
    assign o_rem  = r_rem;

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_x <= i_dividend;
            r_c <= i_carry;
        end
        r_mhi <= w_prod[2*DW-1:DW];
        r_qe  <= DW'(w_qsum >> SH);
        r_re  <= w_re[LW-1:0];
        if (w_rsum >= DIV_S) begin
            r_quot <= {1'b0, r_qe} + (DW+1)'(1);
            r_rem  <= LW'(w_rsum - DIV_S);
        end else begin
            r_quot <= {1'b0, r_qe};
            r_rem  <= w_rsum[LW-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[3:0], i_start};
        end
    end

endmodule

`default_nettype wire

/* hdl/sei_back.sv */
// Back part: session state, energy integration and the result register.
// Depends on sei_pkg and sei_div.
`timescale 1ns / 1ps
`default_nettype none

module sei_back #(
    parameter int STEP_MS = 1000
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_head_valid,
    input  sei_pkg::t_cmd                 i_head,
    output logic                          o_pop,
    output logic                          o_empty,
    input  logic                          i_pop,
    output logic [sei_pkg::STATUS_W-1:0]  o_status,
    output logic                          o_session_active,
    output logic [sei_pkg::ENERGY_W-1:0]  o_energy_half_mws,
    output logic [sei_pkg::REASON_W-1:0]  o_last_reason
);
    import sei_pkg::*;

    localparam int LW = (STEP_MS > 1) ? $clog2(STEP_MS) : 1;
    localparam int QW = STAMP_W + 1;
    localparam int SW = PWR_W + 1;
    localparam int PW = QW + SW;

    t_back_state         r_state;
    t_back_state         n_state;

    logic                r_active;
    logic [ENERGY_W-1:0] r_energy;
    logic [PWR_W-1:0]    r_prev;
    logic [STAMP_W-1:0]  r_last;
    logic [LW-1:0]       r_left;
    logic [REASON_W-1:0] r_reason;

    logic                n_active;
    logic [ENERGY_W-1:0] n_energy;
    logic [PWR_W-1:0]    n_prev;
    logic [STAMP_W-1:0]  n_last;
    logic [LW-1:0]       n_left;
    logic [REASON_W-1:0] n_reason;
    logic [STATUS_W-1:0] n_status;

    logic [PWR_W-1:0]    r_cur_power;
    logic [STAMP_W-1:0]  r_cur_stamp;
    logic [SW-1:0]       r_psum;
    logic [PW-1:0]       r_prod;

    logic                r_out_valid;
    logic [STATUS_W-1:0] r_out_status;
    logic                r_out_active;
    logic [ENERGY_W-1:0] r_out_energy;
    logic [REASON_W-1:0] r_out_reason;

    logic                w_out_free;
    logic                w_arith;
    logic                w_div_start;
    logic                w_ld_simple;
    logic                w_ld_acc;
    logic                w_div_done;
    logic [STAMP_W-1:0]  w_elapsed;
    logic [QW-1:0]       w_quot;
    logic [LW-1:0]       w_rem;
    logic [PW:0]         w_sum;

    assign w_out_free = !r_out_valid || i_pop;
    assign w_arith    = (i_head.kind == KIND_SAMPLE) && r_active
                        && (r_last != '0) && (i_head.stamp != '0);
    assign w_elapsed  = i_head.stamp - r_last;
    assign w_sum      = {1'b0, r_prod} + (PW+1)'(r_energy);

    sei_div #(
        .DIVISOR (STEP_MS),
        .DW      (STAMP_W),
        .LW      (LW)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_elapsed),
        .i_carry    (r_left),
        .o_done     (w_div_done),
        .o_quot     (w_quot),
        .o_rem      (w_rem)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_head_valid && w_arith) n_state = BK_DIV;
            BK_DIV:  if (w_div_done) n_state = BK_MUL;
            BK_MUL:  n_state = BK_ACC;
            BK_ACC:  if (w_out_free) n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        w_div_start = 1'b0;
        w_ld_simple = 1'b0;
        w_ld_acc    = 1'b0;
        unique case (r_state)
            BK_IDLE: begin
                if (i_head_valid && w_arith) begin
                    o_pop       = 1'b1;
                    w_div_start = 1'b1;
                end else if (i_head_valid && w_out_free) begin
                    o_pop       = 1'b1;
                    w_ld_simple = 1'b1;
                end
            end
            BK_DIV: begin
            end
            BK_MUL: begin
            end
            BK_ACC: begin
                w_ld_acc = w_out_free;
            end
        endcase
    end

    always_comb begin
        n_active = r_active;
        n_energy = r_energy;
        n_prev   = r_prev;
        n_last   = r_last;
        n_left   = r_left;
        n_reason = r_reason;
        n_status = STAT_OK;
        if (w_ld_acc) begin
            n_energy = (w_sum >= (PW+1)'(ENERGY_MAX)) ? ENERGY_MAX : w_sum[ENERGY_W-1:0];
            n_prev   = r_cur_power;
            n_last   = r_cur_stamp;
            n_left   = w_rem;
        end else if (w_ld_simple) begin
            unique case (i_head.kind)
                KIND_BEGIN: begin
                    if (r_active) begin
                        n_status = STAT_REJECT;
                    end else begin
                        n_active = 1'b1;
                        n_energy = '0;
                        n_prev   = i_head.power;
                        n_last   = i_head.stamp;
                        n_left   = '0;
                    end
                end
                KIND_FINISH: begin
                    if (!r_active) begin
                        n_status = STAT_REJECT;
                    end else begin
                        n_active = 1'b0;
                        n_reason = i_head.reason;
                        n_prev   = '0;
                        n_last   = '0;
                        n_left   = '0;
                    end
                end
                KIND_SAMPLE: begin
                    // idle clears; active but unprimed or unknown time re-primes
                    n_prev = r_active ? i_head.power : '0;
                    n_last = r_active ? i_head.stamp : '0;
                    n_left = '0;
                end
                KIND_INVALID: begin
                    n_status = STAT_INVALID;
                end
                KIND_REJECT: begin
                    n_status = STAT_REJECT;
                end
                default: begin
                    n_status = STAT_REJECT;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_div_start) begin
            r_cur_power <= i_head.power;
            r_cur_stamp <= i_head.stamp;
            r_psum      <= {1'b0, r_prev} + {1'b0, i_head.power};
        end
        if (r_state == BK_MUL) begin
            r_prod <= PW'(w_quot) * PW'(r_psum);
        end
        if (w_ld_simple || w_ld_acc) begin
            r_out_status <= n_status;
            r_out_active <= n_active;
            r_out_energy <= n_energy;
            r_out_reason <= n_reason;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_active    <= 1'b0;
            r_energy    <= '0;
            r_prev      <= '0;
            r_last      <= '0;
            r_left      <= '0;
            r_reason    <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_active <= n_active;
            r_energy <= n_energy;
            r_prev   <= n_prev;
            r_last   <= n_last;
            r_left   <= n_left;
            r_reason <= n_reason;
            if (w_ld_simple || w_ld_acc) begin
                r_out_valid <= 1'b1;
            end else if (i_pop) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty           = !r_out_valid;
    assign o_status          = r_out_status;
    assign o_session_active  = r_out_active;
    assign o_energy_half_mws = r_out_energy;
    assign o_last_reason     = r_out_reason;

endmodule

`default_nettype wire

/* hdl/session_energy_integrator_top.sv */
// Top level of the session energy integrator: front queue plus back engine.
// Depends on sei_pkg, sei_front, sei_back and the defines header.
`timescale 1ns / 1ps
`default_nettype none

`include "session_energy_integrator_top_defines.svh"

// Meters one charging session. Requests (begin, finish, power sample) enter
// through push/full into a queue of QUEUE_DEPTH entries and give one result
// each, in order, through empty/pop. Begin, finish, invalid samples, the
// unused opcode and samples that only prime the integrator are handled
// directly from idle in the back engine. A sample that integrates is started
// from idle, then passes through the divider by STEP_MS (reciprocal multiply,
// then remainder and carry fix-up), a multiply step and a saturating
// accumulate step. The queue keeps taking requests meanwhile. A result
// waits in an output register, so the back engine keeps going while pop is
// low until the next result is ready.
module session_energy_integrator_top #(
    parameter int STEP_MS     = 1000,
    parameter int QUEUE_DEPTH = 4
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               push,
    output logic                               full,
    input  logic [sei_pkg::OPCODE_W-1:0]       i_opcode,
    input  logic                               i_sample_valid,
    input  logic signed [sei_pkg::POWER_W-1:0] i_power_mw,
    input  logic [sei_pkg::STAMP_W-1:0]        i_stamp_ms,
    input  logic [sei_pkg::REASON_W-1:0]       i_stop_reason,
    output logic                               empty,
    input  logic                               pop,
    output logic [sei_pkg::STATUS_W-1:0]       o_status,
    output logic                               o_session_active,
    output logic [sei_pkg::ENERGY_W-1:0]       o_energy_half_mws,
    output logic [sei_pkg::REASON_W-1:0]       o_last_reason
);
    import sei_pkg::*;

    logic w_head_valid;
    t_cmd w_head;
    logic w_pop;

    sei_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_push         (push),
        .o_full         (full),
        .i_opcode       (i_opcode),
        .i_sample_valid (i_sample_valid),
        .i_power_mw     (i_power_mw),
        .i_stamp_ms     (i_stamp_ms),
        .i_stop_reason  (i_stop_reason),
        .o_head_valid   (w_head_valid),
        .o_head         (w_head),
        .i_pop          (w_pop)
    );

    sei_back #(
        .STEP_MS (STEP_MS)
    ) u_back (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_head_valid      (w_head_valid),
        .i_head            (w_head),
        .o_pop             (w_pop),
        .o_empty           (empty),
        .i_pop             (pop),
        .o_status          (o_status),
        .o_session_active  (o_session_active),
        .o_energy_half_mws (o_energy_half_mws),
        .o_last_reason     (o_last_reason)
    );

    `SEI_ASSERT_IMPL(a_pop_needs_head, i_clk, i_rst_n, w_pop, w_head_valid)
    `SEI_ASSERT_IMPL(a_full_has_head, i_clk, i_rst_n, full, w_head_valid)
    `SEI_ASSERT_NEXT(a_pop_frees_slot, i_clk, i_rst_n, w_pop && !(push && !full), !full)

endmodule

`default_nettype wire

/* tb/tb.sv */
// Self-checking bench for session_energy_integrator_top: directed and random requests,
// a predictor of the metered energy, and random push/pop idling on both sides.
// Depends on sei_pkg and the block's RTL.
`timescale 1ns / 1ps

module tb;
    import sei_pkg::*;

    localparam int STEP_MS     = 1000;
    localparam int ITEM_TARGET = 850;
    localparam int STALL_LIMIT = 1000;
    localparam int TAIL_CYCLES = 40;
    localparam logic [OPCODE_W-1:0] OP_SPARE = 2'd3;

    typedef struct {
        logic [OPCODE_W-1:0] op;
        logic                valid;
        logic [POWER_W-1:0]  power;
        logic [STAMP_W-1:0]  stamp;
        logic [REASON_W-1:0] reason;
    } t_request;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic                active;
        logic [ENERGY_W-1:0] energy;
        logic [REASON_W-1:0] reason;
    } t_reading;

    logic                i_clk = 1'b0;
    logic                i_rst_n = 1'b0;
    logic                push = 1'b0;
    logic                pop = 1'b0;
    logic [OPCODE_W-1:0] i_opcode = '0;
    logic                i_sample_valid = 1'b0;
    logic [POWER_W-1:0]  i_power_mw = '0;
    logic [STAMP_W-1:0]  i_stamp_ms = '0;
    logic [REASON_W-1:0] i_stop_reason = '0;
    logic                full;
    logic                empty;
    logic [STATUS_W-1:0] o_status;
    logic                o_session_active;
    logic [ENERGY_W-1:0] o_energy_half_mws;
    logic [REASON_W-1:0] o_last_reason;

    session_energy_integrator_top #(.STEP_MS(STEP_MS)) dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_opcode         (i_opcode),
        .i_sample_valid   (i_sample_valid),
        .i_power_mw       (i_power_mw),
        .i_stamp_ms       (i_stamp_ms),
        .i_stop_reason    (i_stop_reason),
        .empty            (empty),
        .pop              (pop),
        .o_status         (o_status),
        .o_session_active (o_session_active),
        .o_energy_half_mws(o_energy_half_mws),
        .o_last_reason    (o_last_reason)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    t_request requests_to_send[$];
    t_reading meter_readings[$];
    int       errors = 0;
    int       cycle_count = 0;
    int       idle_cycles = 0;
    int       send_gap = 0;
    int       pop_stall = 0;
    logic     req_taken = 1'b0;
    logic     res_taken = 1'b0;

    // meter state
    logic                meter_active = 1'b0;
    logic [ENERGY_W-1:0] meter_energy = '0;
    logic [PWR_W-1:0]    meter_prev = '0;
    logic [STAMP_W-1:0]  meter_stamp = '0;
    logic [63:0]         meter_leftover = '0;
    logic [REASON_W-1:0] meter_reason = '0;

    function automatic t_reading integrate_request(t_request rq);
        t_reading         rd;
        logic [PWR_W-1:0] pwr;
        logic [STAMP_W-1:0] elapsed;
        logic [63:0]      span;
        logic [63:0]      steps;
        logic [63:0]      add;
        rd.status = STAT_OK;
        pwr = rq.power[POWER_W-1] ? '0 : rq.power[PWR_W-1:0];
        case (rq.op)
            OP_BEGIN: begin
                if (meter_active) begin
                    rd.status = STAT_REJECT;
                end else begin
                    meter_active   = 1'b1;
                    meter_energy   = '0;
                    meter_prev     = rq.valid ? pwr : '0;
                    meter_stamp    = rq.stamp;
                    meter_leftover = '0;
                end
            end
            OP_FINISH: begin
                if (!meter_active) begin
                    rd.status = STAT_REJECT;
                end else begin
                    meter_active   = 1'b0;
                    meter_reason   = rq.reason;
                    meter_prev     = '0;
                    meter_stamp    = '0;
                    meter_leftover = '0;
                end
            end
            OP_SAMPLE: begin
                if (!rq.valid) begin
                    rd.status = STAT_INVALID;
                end else if (!meter_active) begin
                    meter_prev     = '0;
                    meter_stamp    = '0;
                    meter_leftover = '0;
                end else if (meter_stamp == '0 || rq.stamp == '0) begin
                    meter_prev     = pwr;
                    meter_stamp    = rq.stamp;
                    meter_leftover = '0;
                end else begin
                    elapsed        = rq.stamp - meter_stamp;
                    span           = meter_leftover + 64'(elapsed);
                    steps          = span / STEP_MS;
                    meter_leftover = span % STEP_MS;
                    add            = steps * (64'(meter_prev) + 64'(pwr));
                    if (add >= 64'(ENERGY_MAX) - 64'(meter_energy)) begin
                        meter_energy = ENERGY_MAX;
                    end else begin
                        meter_energy = meter_energy + add[ENERGY_W-1:0];
                    end
                    meter_prev  = pwr;
                    meter_stamp = rq.stamp;
                end
            end
            default: begin
                rd.status = STAT_REJECT;
            end
        endcase
        rd.active = meter_active;
        rd.energy = meter_energy;
        rd.reason = meter_reason;
        return rd;
    endfunction

    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if ((cycle_count % 1024) < 200 || r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [POWER_W-1:0] random_power();
        case ($urandom_range(0, 9))
            0: return 24'h7FFFFF;
            1: return 24'h800000;
            2: return '0;
            3, 4, 5: return POWER_W'($urandom);
            default: return POWER_W'($urandom_range(0, 5000000));
        endcase
    endfunction

    function automatic logic [STAMP_W-1:0] random_advance();
        case ($urandom_range(0, 19))
            0: return $urandom;
            1, 2, 3: return $urandom_range(0, 999);
            4: return $urandom_range(100000, 10000000);
            default: return $urandom_range(1, 5000);
        endcase
    endfunction

    task automatic add_request(logic [OPCODE_W-1:0] op, logic valid, logic [POWER_W-1:0] power,
                               logic [STAMP_W-1:0] stamp, logic [REASON_W-1:0] reason);
        t_request rq;
        rq.op     = op;
        rq.valid  = valid;
        rq.power  = power;
        rq.stamp  = stamp;
        rq.reason = reason;
        requests_to_send.push_back(rq);
    endtask

    task automatic add_session();
        logic [STAMP_W-1:0] now;
        int                 n;
        now = ($urandom_range(0, 9) == 0) ? '0 : STAMP_W'($urandom);
        add_request(OP_BEGIN, $urandom_range(0, 7) != 0, random_power(), now, 4'($urandom));
        n = $urandom_range(1, 30);
        repeat (n) begin
            case ($urandom_range(0, 19))
                0: add_request(OP_SAMPLE, 1'b0, random_power(), $urandom, 4'($urandom));
                1: add_request(OP_SAMPLE, 1'b1, random_power(), '0, 4'($urandom));
                2: add_request(OP_BEGIN, 1'($urandom_range(0, 1)), random_power(), $urandom,
                               4'($urandom));
                default: begin
                    now = now + random_advance();
                    add_request(OP_SAMPLE, 1'b1, random_power(), now, 4'($urandom));
                end
            endcase
        end
        if ($urandom_range(0, 9) != 0)
            add_request(OP_FINISH, 1'($urandom_range(0, 1)), random_power(), $urandom,
                        4'($urandom));
    endtask

    always @(negedge i_clk) begin
        t_request rq;
        if (!i_rst_n) begin
            push <= 1'b0;
            pop  <= 1'b0;
        end else begin
            if (push && !req_taken) begin
                // hold the request until it is taken
            end else if (send_gap > 0) begin
                push     <= 1'b0;
                send_gap = send_gap - 1;
            end else if (requests_to_send.size() > 0) begin
                rq = requests_to_send.pop_front();
                i_opcode       <= rq.op;
                i_sample_valid <= rq.valid;
                i_power_mw     <= rq.power;
                i_stamp_ms     <= rq.stamp;
                i_stop_reason  <= rq.reason;
                push           <= 1'b1;
                send_gap = idle_len();
            end else begin
                push <= 1'b0;
            end
            if (res_taken) pop_stall = idle_len();
            if (pop_stall > 0) begin
                pop <= 1'b0;
                pop_stall = pop_stall - 1;
            end else begin
                pop <= 1'b1;
            end
        end
    end

    function automatic void check_field(string name, logic [ENERGY_W-1:0] want,
                                        logic [ENERGY_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_request rq;
        t_reading want;
        if (!i_rst_n) begin
            req_taken   <= 1'b0;
            res_taken   <= 1'b0;
            idle_cycles <= 0;
        end else begin
            cycle_count <= cycle_count + 1;
            req_taken   <= push && !full;
            res_taken   <= pop && !empty;
            if (pop && !empty) begin
                if (meter_readings.size() == 0) begin
                    $error("result with no request outstanding");
                    errors++;
                end else begin
                    want = meter_readings.pop_front();
                    check_field("status", ENERGY_W'(want.status), ENERGY_W'(o_status));
                    check_field("session_active", ENERGY_W'(want.active),
                                ENERGY_W'(o_session_active));
                    check_field("energy_half_mws", want.energy, o_energy_half_mws);
                    check_field("last_reason", ENERGY_W'(want.reason),
                                ENERGY_W'(o_last_reason));
                end
            end
            if (push && !full) begin
                rq.op     = i_opcode;
                rq.valid  = i_sample_valid;
                rq.power  = i_power_mw;
                rq.stamp  = i_stamp_ms;
                rq.reason = i_stop_reason;
                meter_readings.push_back(integrate_request(rq));
            end
            if ((push && !full) || (pop && !empty) ||
                (requests_to_send.size() == 0 && !push && meter_readings.size() == 0)) begin
                idle_cycles <= 0;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("tb: FAIL");
                $finish;
            end
        end
    end

    initial begin
        // directed: idle rejects, priming, wrap, stamp zero, saturation, carry-over
        add_request(OP_SAMPLE, 1'b1, 24'd1234, 32'd5, 4'd3);
        add_request(OP_SAMPLE, 1'b0, 24'h800000, 32'd9, 4'd0);
        add_request(OP_FINISH, 1'b0, '0, '0, 4'd7);
        add_request(OP_SPARE, 1'b1, 24'h7FFFFF, 32'hFFFF_FFFF, 4'd15);
        add_request(OP_BEGIN, 1'b1, 24'h7FFFFF, 32'hFFFF_FF00, 4'd9);
        add_request(OP_BEGIN, 1'b1, 24'd10, 32'd100, 4'd1);
        add_request(OP_SAMPLE, 1'b1, 24'hFFFFFF, 32'h0000_0300, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h7FFFFF, 32'd0, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h7FFFFF, 32'd1, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h7FFFFF, 32'hFFFF_FFFF, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h7FFFFF, 32'hFFFF_FFFE, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h7FFFFF, 32'hFFFF_FFFD, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h7FFFFF, 32'hFFFF_FFFC, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h7FFFFF, 32'hFFFF_FFFB, 4'd0);
        add_request(OP_SAMPLE, 1'b0, 24'h800000, 32'hFFFF_FFFA, 4'd0);
        add_request(OP_FINISH, 1'b1, '0, '0, 4'd15);
        add_request(OP_FINISH, 1'b1, '0, '0, 4'd4);
        add_request(OP_BEGIN, 1'b0, 24'd5, 32'd0, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'h800000, 32'd1000, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'd1, 32'd2999, 4'd0);
        add_request(OP_SAMPLE, 1'b1, 24'd1, 32'd3000, 4'd0);
        add_request(OP_FINISH, 1'b0, '0, '0, 4'd0);

        while (requests_to_send.size() < ITEM_TARGET) begin
            add_session();
            repeat ($urandom_range(0, 3))
                add_request(OP_SPARE & OPCODE_W'($urandom), 1'($urandom_range(0, 1)),
                            random_power(), $urandom, 4'($urandom));
        end

        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        while (requests_to_send.size() > 0 || push || meter_readings.size() > 0)
            @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (meter_readings.size() != 0) begin
            $error("%0d results never arrived", meter_readings.size());
            errors++;
        end
        if (errors == 0) begin
            $display("tb: PASS");
        end else begin
            $display("tb: FAIL");
        end
        $finish;
    end
endmodule
